// File: rtl/nlf_pkg.sv
// Package for the newline line framer: sizes, byte codes, register map and FSM states.
package nlf_pkg;

    localparam int LINE_DEPTH = 64;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);
    localparam int CNT_W      = $clog2(LINE_DEPTH + 1);
    localparam int MAX_LEN_W  = 7;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_RETURN  = 8'h0D;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam logic [0:0] REG_MAX_LEN = 1'b0;

    localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = MAX_LEN_W'(64);

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } t_state;

endpackage

// File: rtl/nlf_in_if.sv
// Input beat channel of the line framer: byte kind and data.
interface nlf_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] data_byte;

    modport source (output valid, output kind, output data_byte, input ready);
    modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

// File: rtl/nlf_out_if.sv
// Output beat channel of the line framer: line bytes and discard reports.
interface nlf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] line_byte;
    logic       is_last;
    logic       discarded;

    modport source (output valid, output line_byte, output is_last, output discarded,
                    input ready);
    modport sink   (input valid, input line_byte, input is_last, input discarded,
                    output ready);
endinterface

// File: rtl/nlf_line_ram.sv
// Line store: one write port, one registered read port that holds when not read.
module nlf_line_ram (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [nlf_pkg::ADDR_W-1:0] i_wr_addr,
    input  logic [7:0]                 i_wr_data,
    input  logic                       i_rd_en,
    input  logic [nlf_pkg::ADDR_W-1:0] i_rd_addr,
    output logic [7:0]                 o_rd_data
);

    logic [7:0] r_mem [nlf_pkg::LINE_DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/newline_line_framer.sv
// Top level of the newline line framer: line collection, emission pipeline and APB register.
//
// Input channel i_in carries one byte beat (kind 0) or a connection-end beat (kind 1).
// Data bytes are written into the line store, one per beat, one per cycle while ready.
// A newline beat closes the line: one trailing carriage return is dropped and the
// rest is read back from the store and sent on o_out, one byte per beat, is_last on
// the final byte. An empty line sends nothing. A line that overruns max_line_length
// is dropped and its newline sends one beat with discarded and is_last set.
// A discard report goes from its newline beat through the read stage and the output
// register. A newline sets the state register to emission; the line's bytes then pass
// the store's read port, a read stage and the output register, one byte per cycle while
// o_out is ready. i_in is not ready while a line is being read out.
// When o_out stalls, the read stage and the output register hold their beats and readout
// pauses; data bytes are still taken while only the output register holds a beat.
// max_line_length lives at APB address 0 (reset 64, values above 64 act as 64).
// Reset clears the line count, the discard flag and the pipeline; the store itself
// is not cleared.
module newline_line_framer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    nlf_in_if.sink                        i_in,
    nlf_out_if.source                     o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nlf_pkg::PADDR_W-1:0]   paddr,
    input  logic [nlf_pkg::PDATA_W-1:0]   pwdata,
    output logic [nlf_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int ADDR_W = nlf_pkg::ADDR_W;
    localparam int CNT_W  = nlf_pkg::CNT_W;
    localparam int LIM_W  = nlf_pkg::MAX_LEN_W;

    nlf_pkg::t_state r_state;
    nlf_pkg::t_state n_state;

    logic [LIM_W-1:0]  r_max_len;
    logic [CNT_W-1:0]  r_count;
    logic              r_last_cr;
    logic              r_discarding;
    logic [ADDR_W-1:0] r_idx;
    logic [CNT_W-1:0]  r_len;
    logic              r_rd_valid;
    logic              r_rd_last;
    logic              r_rd_disc;
    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_out_last;
    logic              r_out_disc;

    logic              in_ready;
    logic              rd_issue;
    logic              in_fire;
    logic              is_data;
    logic              is_nl;
    logic              rd_move;
    logic              report_load;
    logic              wr_en;
    logic              over_limit;
    logic [LIM_W-1:0]  eff_limit;
    logic [CNT_W-1:0]  line_len;
    logic              idx_last;
    logic [7:0]        ram_data;
    logic              cfg_wr;

    assign cfg_wr = psel && penable && pwrite
                    && (paddr[nlf_pkg::PADDR_W-1] == nlf_pkg::REG_MAX_LEN);
    assign pready = 1'b1;
    assign prdata = (paddr[nlf_pkg::PADDR_W-1] == nlf_pkg::REG_MAX_LEN)
                    ? nlf_pkg::PDATA_W'(r_max_len) : '0;

    assign eff_limit = (r_max_len > LIM_W'(nlf_pkg::LINE_DEPTH))
                       ? LIM_W'(nlf_pkg::LINE_DEPTH) : r_max_len;

    assign in_fire     = i_in.valid && in_ready;
    assign is_data     = (i_in.kind == nlf_pkg::KIND_DATA);
    assign is_nl       = is_data && (i_in.data_byte == nlf_pkg::CH_NEWLINE);
    assign over_limit  = (LIM_W'(r_count) >= eff_limit);
    assign wr_en       = in_fire && is_data && !is_nl && !r_discarding && !over_limit;
    assign report_load = in_fire && is_nl && r_discarding;
    assign line_len    = r_count - CNT_W'((r_count != '0) && r_last_cr);
    assign idx_last    = (CNT_W'(r_idx) + CNT_W'(1)) == r_len;
    assign rd_move     = r_rd_valid && (!r_out_valid || o_out.ready);

    nlf_line_ram u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_count[ADDR_W-1:0]),
        .i_wr_data (i_in.data_byte),
        .i_rd_en   (rd_issue),
        .i_rd_addr (r_idx),
        .o_rd_data (ram_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= nlf_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        in_ready = 1'b0;
        rd_issue = 1'b0;
        unique case (r_state)
            nlf_pkg::ST_IDLE: begin
                in_ready = !r_rd_valid || rd_move;
                if (i_in.valid && in_ready && is_nl && !r_discarding
                    && (line_len != '0)) begin
                    n_state = nlf_pkg::ST_EMIT;
                end
            end
            nlf_pkg::ST_EMIT: begin
                rd_issue = !r_rd_valid || rd_move;
                if (rd_issue && idx_last) begin
                    n_state = nlf_pkg::ST_IDLE;
                end
            end
            default: n_state = nlf_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len    <= nlf_pkg::MAX_LEN_RESET;
            r_count      <= '0;
            r_discarding <= 1'b0;
            r_rd_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_max_len <= pwdata[LIM_W-1:0];
            end

            if (in_fire) begin
                if (!is_data || is_nl) begin
                    r_count      <= '0;
                    r_discarding <= 1'b0;
                end else if (!r_discarding) begin
                    if (over_limit) begin
                        r_count      <= '0;
                        r_discarding <= 1'b1;
                    end else begin
                        r_count <= r_count + CNT_W'(1);
                    end
                end
            end

            if (rd_issue || report_load) begin
                r_rd_valid <= 1'b1;
            end else if (rd_move) begin
                r_rd_valid <= 1'b0;
            end

            if (rd_move) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_last_cr <= (i_in.data_byte == nlf_pkg::CH_RETURN);
        end
        if (in_fire && is_nl) begin
            r_idx <= '0;
            r_len <= line_len;
        end else if (rd_issue) begin
            r_idx <= r_idx + ADDR_W'(1);
        end
        if (rd_issue) begin
            r_rd_last <= idx_last;
            r_rd_disc <= 1'b0;
        end else if (report_load) begin
            r_rd_last <= 1'b1;
            r_rd_disc <= 1'b1;
        end
        if (rd_move) begin
            r_out_byte <= r_rd_disc ? 8'h00 : ram_data;
            r_out_last <= r_rd_last;
            r_out_disc <= r_rd_disc;
        end
    end

    assign i_in.ready      = in_ready;
    assign o_out.valid     = r_out_valid;
    assign o_out.line_byte = r_out_byte;
    assign o_out.is_last   = r_out_last;
    assign o_out.discarded = r_out_disc;

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(nlf_pkg::LINE_DEPTH))
        else $error("line count beyond store depth");

    a_report_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.discarded) |-> (o_out.line_byte == 8'h00 && o_out.is_last))
        else $error("discard report carries data or lacks is_last");

    a_newline_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && is_nl) |=> (r_count == '0 && !r_discarding))
        else $error("newline did not clear line state");

    a_rd_stage_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rd_valid && !rd_move) |=> r_rd_valid)
        else $error("read stage beat lost while stalled");

endmodule
